FILE: rtl/core/ir_pwfr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ir_pwfr_pkg
// Shared types and codes of the pulse-width infrared frame receiver.
// ----------------------------------------------------------------------------
package ir_pwfr_pkg;

    localparam int DUR_W       = 16;
    localparam int UNIT_W      = 15;
    localparam int LEN_W       = 13;
    localparam int BYTE_W      = 8;
    localparam int BIT_CNT_W   = 3;
    localparam int SPACE_CNT_W = 8;
    localparam int REG_IDX_W   = 3;

    localparam logic [LEN_W-1:0] BYTE_COUNT_MAX = '1;

    // Register indexes on the configuration port
    localparam logic [REG_IDX_W-1:0] REG_HDR_MARK_MIN  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_HDR_MARK_MAX  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_HDR_SPACE_MIN = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_HDR_SPACE_MAX = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_INTERVAL_MIN  = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_BIT_UNIT      = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_MAX_MSG_BYTES = 3'd6;

    typedef enum logic [2:0] {
        PH_HDR_MARK   = 3'd0,
        PH_HDR_SPACE  = 3'd1,
        PH_DATA_MARK  = 3'd2,
        PH_DATA_SPACE = 3'd3,
        PH_DIV_MARK   = 3'd4,
        PH_DIV_SPACE  = 3'd5
    } t_phase;

    typedef enum logic [2:0] {
        ST_INTERVAL  = 3'd0,
        ST_BIT       = 3'd1,
        ST_BYTE      = 3'd2,
        ST_FRAME_ERR = 3'd3,
        ST_CLEARED   = 3'd4
    } t_status;

    typedef struct packed {
        logic [DUR_W-1:0]  hdr_mark_min;
        logic [DUR_W-1:0]  hdr_mark_max;
        logic [DUR_W-1:0]  hdr_space_min;
        logic [DUR_W-1:0]  hdr_space_max;
        logic [DUR_W-1:0]  interval_min;
        logic [UNIT_W-1:0] bit_unit;
        logic [LEN_W-1:0]  max_msg_bytes;
    } t_cfg;

    typedef struct packed {
        t_status            status;
        logic [BYTE_W-1:0]  byte_value;
        logic [LEN_W-1:0]   byte_index;
        logic               message_ready;
        logic [LEN_W-1:0]   message_length;
    } t_result;

endpackage

FILE: rtl/core/ir_pulse_width_frame_receiver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ir_pulse_width_frame_receiver
// Decodes infrared edge-to-edge intervals into frame bytes and message status.
// ----------------------------------------------------------------------------
// Input channel: i_valid / o_stall carry one beat of {i_cmd, i_duration}; cmd 1
// clears the frame after a message has been consumed, cmd 0 is a timed interval.
// Output channel: o_valid / i_stall carry exactly one result beat per input
// beat, in order: status, the completed byte and its index, message_ready and
// message_length.
// A beat goes from the input register through the frame logic into the result
// register. Throughput is one beat per cycle while the result channel is not
// stalled, set by the frame state update.
// A stalled result holds in the result register; the input register keeps
// accepting until it too is full, then o_stall rises.
// Reset (synchronous, active low) empties both registers, returns the frame to
// header-mark search, zeroes the space counter and restores register defaults.
// Registers are written over the APB-style port at byte address 4*index.
// ----------------------------------------------------------------------------
module ir_pulse_width_frame_receiver #(
    parameter int BLOCK_BYTES = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic                                i_cmd,
    input  logic [ir_pwfr_pkg::DUR_W-1:0]       i_duration,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [2:0]                          o_status,
    output logic [ir_pwfr_pkg::BYTE_W-1:0]      o_byte_value,
    output logic [ir_pwfr_pkg::LEN_W-1:0]       o_byte_index,
    output logic                                o_message_ready,
    output logic [ir_pwfr_pkg::LEN_W-1:0]       o_message_length,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [4:0]                          paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);

    ir_pwfr_pkg::t_cfg    cfg;
    ir_pwfr_pkg::t_result result;
    ir_pwfr_pkg::t_result r_out;

    logic                              r_in_valid;
    logic                              r_in_cmd;
    logic [ir_pwfr_pkg::DUR_W-1:0]     r_in_duration;
    logic                              r_out_valid;
    logic                              out_blocked;
    logic                              advance;

    assign out_blocked = r_out_valid && i_stall;
    assign advance     = r_in_valid && !out_blocked;
    assign o_stall     = r_in_valid && out_blocked;

    ir_pwfr_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    ir_pwfr_decoder #(
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_decoder (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_go       (advance),
        .i_cmd      (r_in_cmd),
        .i_duration (r_in_duration),
        .i_cfg      (cfg),
        .o_result   (result)
    );

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in_cmd      <= i_cmd;
            r_in_duration <= i_duration;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= result;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_status         = r_out.status;
    assign o_byte_value     = r_out.byte_value;
    assign o_byte_index     = r_out.byte_index;
    assign o_message_ready  = r_out.message_ready;
    assign o_message_length = r_out.message_length;

endmodule

FILE: rtl/core/ir_pwfr_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ir_pwfr_cfg_regs
// APB-style register file holding the timing windows and the length limit.
// ----------------------------------------------------------------------------
module ir_pwfr_cfg_regs (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output ir_pwfr_pkg::t_cfg   o_cfg
);

    ir_pwfr_pkg::t_cfg r_cfg;
    logic [ir_pwfr_pkg::REG_IDX_W-1:0] reg_idx;
    logic wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.hdr_mark_min  <= 16'd8000;
            r_cfg.hdr_mark_max  <= 16'd10000;
            r_cfg.hdr_space_min <= 16'd4000;
            r_cfg.hdr_space_max <= 16'd5000;
            r_cfg.interval_min  <= 16'd100;
            r_cfg.bit_unit      <= 15'd500;
            r_cfg.max_msg_bytes <= 13'd1024;
        end else if (wr_en) begin
            unique case (reg_idx)
                ir_pwfr_pkg::REG_HDR_MARK_MIN:  r_cfg.hdr_mark_min  <= pwdata[15:0];
                ir_pwfr_pkg::REG_HDR_MARK_MAX:  r_cfg.hdr_mark_max  <= pwdata[15:0];
                ir_pwfr_pkg::REG_HDR_SPACE_MIN: r_cfg.hdr_space_min <= pwdata[15:0];
                ir_pwfr_pkg::REG_HDR_SPACE_MAX: r_cfg.hdr_space_max <= pwdata[15:0];
                ir_pwfr_pkg::REG_INTERVAL_MIN:  r_cfg.interval_min  <= pwdata[15:0];
                ir_pwfr_pkg::REG_BIT_UNIT:      r_cfg.bit_unit      <= pwdata[14:0];
                ir_pwfr_pkg::REG_MAX_MSG_BYTES: r_cfg.max_msg_bytes <= pwdata[12:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            ir_pwfr_pkg::REG_HDR_MARK_MIN:  prdata = {16'd0, r_cfg.hdr_mark_min};
            ir_pwfr_pkg::REG_HDR_MARK_MAX:  prdata = {16'd0, r_cfg.hdr_mark_max};
            ir_pwfr_pkg::REG_HDR_SPACE_MIN: prdata = {16'd0, r_cfg.hdr_space_min};
            ir_pwfr_pkg::REG_HDR_SPACE_MAX: prdata = {16'd0, r_cfg.hdr_space_max};
            ir_pwfr_pkg::REG_INTERVAL_MIN:  prdata = {16'd0, r_cfg.interval_min};
            ir_pwfr_pkg::REG_BIT_UNIT:      prdata = {17'd0, r_cfg.bit_unit};
            ir_pwfr_pkg::REG_MAX_MSG_BYTES: prdata = {19'd0, r_cfg.max_msg_bytes};
            default:                        prdata = 32'd0;
        endcase
    end

endmodule

FILE: rtl/core/ir_pwfr_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ir_pwfr_decoder
// Frame FSM and bit packer; one interval or clear beat per cycle with i_go.
// ----------------------------------------------------------------------------
module ir_pwfr_decoder #(
    parameter int BLOCK_BYTES = 32
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_go,
    input  logic                                  i_cmd,
    input  logic [ir_pwfr_pkg::DUR_W-1:0]         i_duration,
    input  ir_pwfr_pkg::t_cfg                     i_cfg,
    output ir_pwfr_pkg::t_result                  o_result
);

    localparam int LEN_W  = ir_pwfr_pkg::LEN_W;
    localparam int BYTE_W = ir_pwfr_pkg::BYTE_W;
    localparam int PROD_W = BYTE_W + $clog2(BLOCK_BYTES + 1);
    localparam int TOT_W  = PROD_W + 1;
    localparam int CMP_W  = (TOT_W > LEN_W) ? TOT_W : LEN_W;
    localparam logic [TOT_W-1:0] BB_TOT = TOT_W'(BLOCK_BYTES);

    ir_pwfr_pkg::t_phase r_phase, n_phase;
    logic [BYTE_W-1:0]                    r_shift, n_shift;
    logic [ir_pwfr_pkg::BIT_CNT_W-1:0]    r_bit_cnt, n_bit_cnt;
    logic [LEN_W-1:0]                     r_byte_cnt, n_byte_cnt;
    logic [BYTE_W-1:0]                    r_blk, n_blk;
    logic [BYTE_W-1:0]                    r_last, n_last;
    logic [ir_pwfr_pkg::SPACE_CNT_W-1:0]  r_space_cnt, n_space_cnt;

    logic in_header, win_mark, win_space, frame_err, clear, mark_one;
    logic [BYTE_W-1:0] shifted;
    logic [TOT_W-1:0]  total;
    logic              total_pos, len_ok;
    logic [LEN_W-1:0]  len;
    logic [LEN_W:0]    len_plus2;

    ir_pwfr_pkg::t_status res_status;
    logic [BYTE_W-1:0]    res_byte;
    logic [LEN_W-1:0]     res_index;
    logic                 msg_ready;

    assign in_header = (r_phase == ir_pwfr_pkg::PH_HDR_MARK)
                    || (r_phase == ir_pwfr_pkg::PH_HDR_SPACE);
    assign win_mark  = (i_duration >= i_cfg.hdr_mark_min) && (i_duration <= i_cfg.hdr_mark_max);
    assign win_space = (i_duration >= i_cfg.hdr_space_min)
                    && (i_duration <= i_cfg.hdr_space_max);
    assign frame_err = !i_cmd && (((i_duration > i_cfg.hdr_mark_max) && in_header)
                    || (i_duration < i_cfg.interval_min)
                    || ((r_phase == ir_pwfr_pkg::PH_HDR_MARK) && !win_mark)
                    || ((r_phase == ir_pwfr_pkg::PH_HDR_SPACE) && !win_space));
    assign clear     = i_cmd || frame_err;
    assign mark_one  = i_duration > {i_cfg.bit_unit, 1'b0};
    assign shifted   = {r_shift[BYTE_W-2:0], mark_one};

    // Next phase
    always_comb begin
        n_phase = r_phase;
        if (i_go) begin
            if (clear) begin
                n_phase = ir_pwfr_pkg::PH_HDR_MARK;
            end else begin
                unique case (r_phase)
                    ir_pwfr_pkg::PH_HDR_MARK:   n_phase = ir_pwfr_pkg::PH_HDR_SPACE;
                    ir_pwfr_pkg::PH_HDR_SPACE:  n_phase = ir_pwfr_pkg::PH_DATA_MARK;
                    ir_pwfr_pkg::PH_DATA_MARK:  n_phase = ir_pwfr_pkg::PH_DATA_SPACE;
                    ir_pwfr_pkg::PH_DATA_SPACE: begin
                        // every 256th space is followed by a divider interval
                        n_phase = (&r_space_cnt) ? ir_pwfr_pkg::PH_DIV_SPACE
                                                 : ir_pwfr_pkg::PH_DATA_MARK;
                    end
                    ir_pwfr_pkg::PH_DIV_MARK:   n_phase = ir_pwfr_pkg::PH_DIV_SPACE;
                    ir_pwfr_pkg::PH_DIV_SPACE:  n_phase = ir_pwfr_pkg::PH_DATA_MARK;
                    default:                    n_phase = r_phase;
                endcase
            end
        end
    end

    // Datapath and result
    always_comb begin
        n_shift     = r_shift;
        n_bit_cnt   = r_bit_cnt;
        n_byte_cnt  = r_byte_cnt;
        n_blk       = r_blk;
        n_last      = r_last;
        n_space_cnt = r_space_cnt;
        res_status  = ir_pwfr_pkg::ST_INTERVAL;
        res_byte    = '0;
        res_index   = '0;
        if (i_go) begin
            if (clear) begin
                n_shift    = '0;
                n_bit_cnt  = '0;
                n_byte_cnt = '0;
                n_blk      = '0;
                n_last     = '0;
                res_status = i_cmd ? ir_pwfr_pkg::ST_CLEARED : ir_pwfr_pkg::ST_FRAME_ERR;
            end else if (r_phase == ir_pwfr_pkg::PH_DATA_MARK) begin
                n_bit_cnt = r_bit_cnt + 1'b1;
                if (&r_bit_cnt) begin
                    res_status = ir_pwfr_pkg::ST_BYTE;
                    res_byte   = shifted;
                    res_index  = r_byte_cnt;
                    if (r_byte_cnt == '0) begin
                        n_blk = shifted;
                    end else if (r_byte_cnt == LEN_W'(1)) begin
                        n_last = shifted;
                    end
                    if (r_byte_cnt != ir_pwfr_pkg::BYTE_COUNT_MAX) begin
                        n_byte_cnt = r_byte_cnt + 1'b1;
                    end
                    n_shift = '0;
                end else begin
                    res_status = ir_pwfr_pkg::ST_BIT;
                    n_shift    = shifted;
                end
            end else if (r_phase == ir_pwfr_pkg::PH_DATA_SPACE) begin
                n_space_cnt = r_space_cnt + 1'b1;
            end
        end
    end

    // Stated length from the post-beat header bytes; block count zero leaves
    // last minus one block, positive only when last exceeds the block size.
    always_comb begin
        if (n_blk == '0) begin
            total_pos = TOT_W'(n_last) > BB_TOT;
            total     = TOT_W'(n_last) - BB_TOT;
        end else begin
            total     = TOT_W'(PROD_W'(n_blk - 1'b1) * PROD_W'(BLOCK_BYTES)) + TOT_W'(n_last);
            total_pos = total != '0;
        end
        len_ok = (n_byte_cnt >= LEN_W'(2)) && total_pos
              && (CMP_W'(total) <= CMP_W'(i_cfg.max_msg_bytes));
        len    = len_ok ? total[LEN_W-1:0] : '0;
    end

    assign len_plus2 = {1'b0, len} + (LEN_W + 1)'(2);
    assign msg_ready = (len != '0) && (n_byte_cnt >= LEN_W'(3))
                    && ({1'b0, n_byte_cnt} >= len_plus2);
    assign o_result  = {res_status, res_byte, res_index, msg_ready, len};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= ir_pwfr_pkg::PH_HDR_MARK;
            r_shift     <= '0;
            r_bit_cnt   <= '0;
            r_byte_cnt  <= '0;
            r_blk       <= '0;
            r_last      <= '0;
            r_space_cnt <= '0;
        end else begin
            r_phase     <= n_phase;
            r_shift     <= n_shift;
            r_bit_cnt   <= n_bit_cnt;
            r_byte_cnt  <= n_byte_cnt;
            r_blk       <= n_blk;
            r_last      <= n_last;
            r_space_cnt <= n_space_cnt;
        end
    end

endmodule

FILE: rtl/core/ir_pwfr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ir_pwfr_sva
// Port-level checks on the result channel of the frame receiver.
// ----------------------------------------------------------------------------
module ir_pwfr_sva (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_stall,
    input logic [2:0]  o_status,
    input logic [7:0]  o_byte_value,
    input logic [12:0] o_byte_index,
    input logic        o_message_ready,
    input logic [12:0] o_message_length
);

    // hold a stalled result beat
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_status) && $stable(o_byte_value))
        else $error("stalled result beat changed");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_status <= 3'(ir_pwfr_pkg::ST_CLEARED))
        else $error("status code out of range");

    a_byte_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status != 3'(ir_pwfr_pkg::ST_BYTE))
        |-> (o_byte_value == 8'd0) && (o_byte_index == 13'd0))
        else $error("byte fields set without a completed byte");

    a_ready_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_message_ready |-> (o_message_length != 13'd0)
        && (o_message_length <= 13'd8189))
        else $error("message ready without a valid length");

    a_clear_drops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && ((o_status == 3'(ir_pwfr_pkg::ST_CLEARED))
        || (o_status == 3'(ir_pwfr_pkg::ST_FRAME_ERR)))
        |-> !o_message_ready && (o_message_length == 13'd0))
        else $error("frame reset left message state");

endmodule

bind ir_pulse_width_frame_receiver ir_pwfr_sva u_ir_pwfr_sva (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_valid          (o_valid),
    .i_stall          (i_stall),
    .o_status         (o_status),
    .o_byte_value     (o_byte_value),
    .o_byte_index     (o_byte_index),
    .o_message_ready  (o_message_ready),
    .o_message_length (o_message_length)
);

FILE: test/ir_pwfr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ir_pwfr_checker
// Watches the interval and result channels and the register port of the frame
// receiver. It decodes every accepted interval beat with its own copy of the
// frame state and registers. It then compares each result beat, in order,
// against the oldest decoded beat still waiting.
// ----------------------------------------------------------------------------
module ir_pwfr_checker #(
    parameter int BLOCK_BYTES = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            i_in_stall,
    input  logic                            i_cmd,
    input  logic [ir_pwfr_pkg::DUR_W-1:0]   i_duration,
    input  logic                            i_out_valid,
    input  logic                            i_out_stall,
    input  logic [2:0]                      i_status,
    input  logic [ir_pwfr_pkg::BYTE_W-1:0]  i_byte_value,
    input  logic [ir_pwfr_pkg::LEN_W-1:0]   i_byte_index,
    input  logic                            i_message_ready,
    input  logic [ir_pwfr_pkg::LEN_W-1:0]   i_message_length,
    input  logic                            i_psel,
    input  logic                            i_penable,
    input  logic                            i_pwrite,
    input  logic                            i_pready,
    input  logic [4:0]                      i_paddr,
    input  logic [31:0]                     i_pwdata,
    output int                              o_mismatches,
    output int                              o_pending
);
    import ir_pwfr_pkg::*;

    t_cfg              cfg;
    t_phase            phase;
    logic [BYTE_W-1:0] shift_reg;
    logic [2:0]        bit_cnt;
    logic [LEN_W-1:0]  byte_cnt;
    logic [BYTE_W-1:0] block_cnt_byte;
    logic [BYTE_W-1:0] last_blk_bytes;
    logic [7:0]        space_cnt;
    t_result           decoded_beats[$];
    int                mismatches;

    function automatic void drop_frame();
        phase          = PH_HDR_MARK;
        shift_reg      = '0;
        bit_cnt        = '0;
        byte_cnt       = '0;
        block_cnt_byte = '0;
        last_blk_bytes = '0;
    endfunction

    function automatic t_result decode_beat(input logic clear_req,
                                            input logic [DUR_W-1:0] dur);
        t_result r;
        int      d;
        int      unit2;
        int      blocks;
        int      last;
        int      total;
        int      max_len;
        int      len;
        int      nb;
        r     = '0;
        d     = dur;
        unit2 = cfg.bit_unit;
        unit2 = unit2 * 2;
        if (clear_req) begin
            drop_frame();
            r.status = ST_CLEARED;
        end else if ((dur > cfg.hdr_mark_max && phase < PH_DATA_MARK) ||
                     dur < cfg.interval_min) begin
            drop_frame();
            r.status = ST_FRAME_ERR;
        end else begin
            case (phase)
                PH_HDR_MARK: begin
                    if (dur >= cfg.hdr_mark_min && dur <= cfg.hdr_mark_max) begin
                        phase = PH_HDR_SPACE;
                    end else begin
                        drop_frame();
                        r.status = ST_FRAME_ERR;
                    end
                end
                PH_HDR_SPACE: begin
                    if (dur >= cfg.hdr_space_min && dur <= cfg.hdr_space_max) begin
                        phase = PH_DATA_MARK;
                    end else begin
                        drop_frame();
                        r.status = ST_FRAME_ERR;
                    end
                end
                PH_DATA_MARK: begin
                    shift_reg = {shift_reg[BYTE_W-2:0], (d > unit2)};
                    bit_cnt   = bit_cnt + 3'd1;
                    if (bit_cnt == 3'd0) begin
                        r.status     = ST_BYTE;
                        r.byte_value = shift_reg;
                        r.byte_index = byte_cnt;
                        // the first two bytes carry the length header
                        if (byte_cnt == 0) begin
                            block_cnt_byte = shift_reg;
                        end else if (byte_cnt == 1) begin
                            last_blk_bytes = shift_reg;
                        end
                        if (byte_cnt < BYTE_COUNT_MAX) begin
                            byte_cnt = byte_cnt + 1'b1;
                        end
                        shift_reg = '0;
                    end else begin
                        r.status = ST_BIT;
                    end
                    phase = PH_DATA_SPACE;
                end
                PH_DATA_SPACE: begin
                    space_cnt = space_cnt + 8'd1;
                    phase     = (space_cnt == 8'd0) ? PH_DIV_SPACE : PH_DATA_MARK;
                end
                PH_DIV_MARK: begin
                    phase = PH_DIV_SPACE;
                end
                PH_DIV_SPACE: begin
                    phase = PH_DATA_MARK;
                end
                default: begin
                end
            endcase
        end

        len     = 0;
        nb      = byte_cnt;
        max_len = cfg.max_msg_bytes;
        if (nb >= 2) begin
            blocks = block_cnt_byte;
            last   = last_blk_bytes;
            total  = (blocks - 1) * BLOCK_BYTES + last;
            if (total > 0 && total <= max_len) begin
                len = total;
            end
        end
        r.message_ready  = (len != 0 && nb >= 3 && nb >= len + 2);
        r.message_length = LEN_W'(len);
        return r;
    endfunction

    always @(posedge i_clk) begin : monitor
        t_result want;
        if (!i_rst_n) begin
            cfg.hdr_mark_min  = 16'd8000;
            cfg.hdr_mark_max  = 16'd10000;
            cfg.hdr_space_min = 16'd4000;
            cfg.hdr_space_max = 16'd5000;
            cfg.interval_min  = 16'd100;
            cfg.bit_unit      = 15'd500;
            cfg.max_msg_bytes = 13'd1024;
            drop_frame();
            space_cnt = '0;
            decoded_beats.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (decoded_beats.size() == 0) begin
                    if (mismatches < 10) begin
                        $display("result beat with nothing pending: status %0d byte %02h",
                                 i_status, i_byte_value);
                    end
                    mismatches++;
                end else begin
                    want = decoded_beats.pop_front();
                    if (i_status !== want.status || i_byte_value !== want.byte_value ||
                        i_byte_index !== want.byte_index ||
                        i_message_ready !== want.message_ready ||
                        i_message_length !== want.message_length) begin
                        if (mismatches < 10) begin
                            $display("beat mismatch: expected status %0d byte %02h idx %0d rdy %0b len %0d",
                                     want.status, want.byte_value, want.byte_index,
                                     want.message_ready, want.message_length);
                            $display("               got      status %0d byte %02h idx %0d rdy %0b len %0d",
                                     i_status, i_byte_value, i_byte_index,
                                     i_message_ready, i_message_length);
                        end
                        mismatches++;
                    end
                end
            end

            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[4:2])
                    REG_HDR_MARK_MIN:  cfg.hdr_mark_min  = i_pwdata[15:0];
                    REG_HDR_MARK_MAX:  cfg.hdr_mark_max  = i_pwdata[15:0];
                    REG_HDR_SPACE_MIN: cfg.hdr_space_min = i_pwdata[15:0];
                    REG_HDR_SPACE_MAX: cfg.hdr_space_max = i_pwdata[15:0];
                    REG_INTERVAL_MIN:  cfg.interval_min  = i_pwdata[15:0];
                    REG_BIT_UNIT:      cfg.bit_unit      = i_pwdata[14:0];
                    REG_MAX_MSG_BYTES: cfg.max_msg_bytes = i_pwdata[12:0];
                    default: begin
                    end
                endcase
            end

            if (i_in_valid && !i_in_stall) begin
                decoded_beats.push_back(decode_beat(i_cmd, i_duration));
            end
        end
        o_mismatches <= mismatches;
        o_pending    <= decoded_beats.size();
    end

    initial begin
        mismatches = 0;
    end

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives the pulse-width frame receiver with edge intervals and clear
// commands: a short directed run at reset settings, then random frames under
// several register settings and idling and stall patterns. The checker beside the block
// decodes and compares every result beat.
// ----------------------------------------------------------------------------
module tb;
    import ir_pwfr_pkg::*;

    localparam int   BLOCK_BYTES    = 32;
    localparam int   WATCHDOG_LIMIT = 5000;
    localparam logic CMD_INTERVAL   = 1'b0;
    localparam logic CMD_CLEAR      = 1'b1;
    localparam logic [REG_IDX_W-1:0] REG_UNUSED = 3'd7;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_stall;
    logic              i_cmd;
    logic [DUR_W-1:0]  i_duration;
    logic              o_valid;
    logic              i_stall;
    logic [2:0]        o_status;
    logic [BYTE_W-1:0] o_byte_value;
    logic [LEN_W-1:0]  o_byte_index;
    logic              o_message_ready;
    logic [LEN_W-1:0]  o_message_length;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [4:0]        paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    int   mismatches;
    int   pending;
    int   idle_pct;
    int   stall_pct;
    int   intervals_sent;
    int   beat_stop;
    int   data_spaces;
    int   quiet_cycles;
    t_cfg cur_cfg;

    ir_pulse_width_frame_receiver #(
        .BLOCK_BYTES(BLOCK_BYTES)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_cmd           (i_cmd),
        .i_duration      (i_duration),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_status        (o_status),
        .o_byte_value    (o_byte_value),
        .o_byte_index    (o_byte_index),
        .o_message_ready (o_message_ready),
        .o_message_length(o_message_length),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    ir_pwfr_checker #(
        .BLOCK_BYTES(BLOCK_BYTES)
    ) u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_valid),
        .i_in_stall      (o_stall),
        .i_cmd           (i_cmd),
        .i_duration      (i_duration),
        .i_out_valid     (o_valid),
        .i_out_stall     (i_stall),
        .i_status        (o_status),
        .i_byte_value    (o_byte_value),
        .i_byte_index    (o_byte_index),
        .i_message_ready (o_message_ready),
        .i_message_length(o_message_length),
        .i_psel          (psel),
        .i_penable       (penable),
        .i_pwrite        (pwrite),
        .i_pready        (pready),
        .i_paddr         (paddr),
        .i_pwdata        (pwdata),
        .o_mismatches    (mismatches),
        .o_pending       (pending)
    );

    always #10 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    function automatic t_cfg make_cfg(input int mark_min, input int mark_max,
                                      input int space_min, input int space_max,
                                      input int ival_min, input int unit,
                                      input int max_bytes);
        t_cfg c;
        c.hdr_mark_min  = DUR_W'(mark_min);
        c.hdr_mark_max  = DUR_W'(mark_max);
        c.hdr_space_min = DUR_W'(space_min);
        c.hdr_space_max = DUR_W'(space_max);
        c.interval_min  = DUR_W'(ival_min);
        c.bit_unit      = UNIT_W'(unit);
        c.max_msg_bytes = LEN_W'(max_bytes);
        return c;
    endfunction

    // Random value in [lo, hi], landing on either bound now and then.
    function automatic int pick_in(input int lo, input int hi);
        int r;
        r = $urandom_range(0, 9);
        if (lo >= hi || r == 0) return lo;
        if (r == 1) return hi;
        return $urandom_range(hi, lo);
    endfunction

    function automatic int mark_for(input logic one);
        int unit2;
        int imin;
        unit2 = cur_cfg.bit_unit;
        unit2 = unit2 * 2;
        imin  = cur_cfg.interval_min;
        if (one) return pick_in((unit2 + 1 > imin) ? unit2 + 1 : imin, 65535);
        return pick_in(imin, unit2);
    endfunction

    // Random bits above the register width check that the block masks them.
    function automatic logic [31:0] with_junk(input int value, input int width);
        logic [31:0] mask;
        mask = (32'd1 << width) - 32'd1;
        return ($urandom() & ~mask) | (32'(value) & mask);
    endfunction

    task automatic send_beat(input logic cmd, input int dur);
        while ($urandom_range(0, 99) < idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid    <= 1'b1;
        i_cmd      <= cmd;
        i_duration <= DUR_W'(dur);
        do @(posedge i_clk); while (o_stall);
        intervals_sent++;
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] word);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= word;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic load_config(input t_cfg c);
        write_reg(REG_HDR_MARK_MIN,  with_junk(c.hdr_mark_min, DUR_W));
        write_reg(REG_HDR_MARK_MAX,  with_junk(c.hdr_mark_max, DUR_W));
        write_reg(REG_HDR_SPACE_MIN, with_junk(c.hdr_space_min, DUR_W));
        write_reg(REG_HDR_SPACE_MAX, with_junk(c.hdr_space_max, DUR_W));
        write_reg(REG_INTERVAL_MIN,  with_junk(c.interval_min, DUR_W));
        write_reg(REG_BIT_UNIT,      with_junk(c.bit_unit, UNIT_W));
        write_reg(REG_MAX_MSG_BYTES, with_junk(c.max_msg_bytes, LEN_W));
        write_reg(REG_UNUSED,        $urandom());
        cur_cfg = c;
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // One frame: header, length bytes, payload; now and then broken by noise,
    // a stray clear or a bad header. Cut short once the phase budget is spent.
    task automatic send_frame();
        int         blocks;
        int         last;
        int         len;
        int         nbytes;
        int         imin;
        int         k;
        int         j;
        logic [7:0] data;
        imin   = cur_cfg.interval_min;
        blocks = 1;
        if ($urandom_range(0, 19) == 0) begin
            blocks = $urandom_range(0, 255);
        end else if ($urandom_range(0, 9) == 0) begin
            blocks = $urandom_range(0, 2);
        end
        last = $urandom_range(0, 7);
        len  = (blocks - 1) * BLOCK_BYTES + last;
        if (len > 0 && len <= 40 && $urandom_range(0, 3) != 0) begin
            nbytes = len + 2 + $urandom_range(0, 1);
        end else begin
            nbytes = $urandom_range(0, 5);
        end

        if ($urandom_range(0, 9) == 0) begin
            send_beat(CMD_INTERVAL, $urandom_range(0, 65535));
        end else begin
            send_beat(CMD_INTERVAL, pick_in(cur_cfg.hdr_mark_min, cur_cfg.hdr_mark_max));
        end
        send_beat(CMD_INTERVAL, pick_in(cur_cfg.hdr_space_min, cur_cfg.hdr_space_max));

        for (k = 0; k < nbytes && intervals_sent < beat_stop; k++) begin
            data = (k == 0) ? blocks[7:0] : (k == 1) ? last[7:0] : 8'($urandom());
            for (j = 7; j >= 0 && intervals_sent < beat_stop; j--) begin
                send_beat(CMD_INTERVAL, mark_for(data[j]));
                case ($urandom_range(0, 399))
                    0: send_beat(CMD_INTERVAL, (imin > 0) ? $urandom_range(0, imin - 1) : 0);
                    1: send_beat(CMD_CLEAR, $urandom_range(0, 65535));
                    default: begin
                    end
                endcase
                send_beat(CMD_INTERVAL, pick_in(imin, 65535));
                data_spaces++;
                // insert the block divider after every 256 data spaces
                if (data_spaces % 256 == 0) begin
                    send_beat(CMD_INTERVAL, pick_in(imin, 65535));
                end
            end
        end
        if ($urandom_range(0, 1) == 0) begin
            send_beat(CMD_CLEAR, $urandom_range(0, 65535));
        end
    endtask

    task automatic run_random(input int budget);
        int mode;
        for (mode = 0; mode < 4; mode++) begin
            idle_pct  <= (mode == 1) ? 60 : (mode == 3) ? 17 : 0;
            stall_pct <= (mode == 2) ? 60 : (mode == 3) ? 17 : 0;
            beat_stop = intervals_sent + budget / 4;
            while (intervals_sent < beat_stop) begin
                if ($urandom_range(0, 9) == 0) begin
                    send_beat(($urandom_range(0, 3) == 0) ? CMD_CLEAR : CMD_INTERVAL,
                              $urandom_range(0, 65535));
                end else begin
                    send_frame();
                end
            end
        end
    endtask

    initial begin : watchdog
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("ir_pulse_width_frame_receiver test failed");
        $finish;
    end

    initial begin : stimulus
        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_cmd          = CMD_INTERVAL;
        i_duration     = '0;
        i_stall        = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        idle_pct       = 0;
        stall_pct      = 0;
        intervals_sent = 0;
        beat_stop      = 0;
        data_spaces    = 0;
        cur_cfg        = make_cfg(8000, 10000, 4000, 5000, 100, 500, 1024);
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Header windows, noise and clear at reset settings
        send_beat(CMD_CLEAR, 0);
        send_beat(CMD_INTERVAL, 0);
        send_beat(CMD_INTERVAL, 99);
        send_beat(CMD_INTERVAL, 65535);
        send_beat(CMD_INTERVAL, 10001);
        send_beat(CMD_INTERVAL, 7999);
        send_beat(CMD_INTERVAL, 8000);
        send_beat(CMD_INTERVAL, 3999);
        send_beat(CMD_INTERVAL, 10000);
        send_beat(CMD_INTERVAL, 5001);
        send_beat(CMD_INTERVAL, 8000);
        send_beat(CMD_INTERVAL, 4000);
        // Bit threshold and long marks in the data phase
        send_beat(CMD_INTERVAL, 1001);
        send_beat(CMD_INTERVAL, 100);
        send_beat(CMD_INTERVAL, 1000);
        send_beat(CMD_INTERVAL, 65535);
        send_beat(CMD_INTERVAL, 65535);
        send_beat(CMD_INTERVAL, 12345);
        send_beat(CMD_INTERVAL, 99);
        send_beat(CMD_INTERVAL, 9000);
        send_beat(CMD_INTERVAL, 4500);
        send_beat(CMD_INTERVAL, 2000);
        send_beat(CMD_CLEAR, 65535);
        wait_drained();

        load_config(make_cfg(8000, 10000, 4000, 5000, 100, 500, 1024));
        run_random(240);
        wait_drained();

        load_config(make_cfg(0, 65535, 0, 65535, 0, 1, 1));
        run_random(160);
        wait_drained();

        load_config(make_cfg(65535, 65535, 65535, 65535, 65535, 32767, 8191));
        run_random(40);
        wait_drained();

        repeat (2) begin
            load_config(make_cfg($urandom_range(0, 20000), $urandom_range(20000, 26000),
                                 $urandom_range(0, 8000), $urandom_range(8000, 12000),
                                 $urandom_range(0, 400), $urandom_range(1, 3000),
                                 $urandom_range(1, 80)));
            run_random(160);
            wait_drained();
        end

        if (mismatches == 0) begin
            $display("ir_pulse_width_frame_receiver test passed");
        end else begin
            $display("ir_pulse_width_frame_receiver test failed");
        end
        $finish;
    end

endmodule
